/* design/cpbt_pkg.sv */
// Shared types, fixed-point constants and helper functions for the camera-to-base transform.
`timescale 1ns / 1ps
`default_nettype none
package cpbt_pkg;

  // Field types
  typedef logic signed [23:0] coord_t;
  typedef logic signed [18:0] angle_t;
  typedef logic [19:0]        offset_t;

  // Working vector between stages, micrometres
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // Flange position carried down the pipe
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } flange_t;

  // Cosine and sine of one angle, Q1.30
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  // Workspace box and approach height, from the register file
  typedef struct packed {
    coord_t  x_lo;
    coord_t  x_hi;
    coord_t  y_lo;
    coord_t  y_hi;
    coord_t  z_lo;
    coord_t  z_hi;
    offset_t approach;
  } limits_t;

  // Register indexes
  typedef enum logic [2:0] {
    CFG_X_LO,
    CFG_X_HI,
    CFG_Y_LO,
    CFG_Y_HI,
    CFG_Z_LO,
    CFG_Z_HI,
    CFG_APPROACH
  } cfg_reg_t;

  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Decimal coefficient in units of 1e-10 to Q1.30, nearest
  function automatic longint qcoef(longint c);
    return (c * 1048576 + ((c < 0) ? -4882812 : 4882812)) / 9765625;
  endfunction

  // Offset in units of 1e-4 um to Q.30 um, nearest
  function automatic longint qoff(longint k);
    return (k * 67108864 + ((k < 0) ? -312 : 312)) / 625;
  endfunction

  // Hand-eye rotation, row major
  localparam logic signed [31:0] HE_COEF [9] = '{
    32'(qcoef(-64'sd23177327)),   32'(qcoef(64'sd9998959726)), 32'(qcoef(-64'sd142362951)),
    32'(qcoef(-64'sd9997701357)), 32'(qcoef(-64'sd26204112)),  32'(qcoef(-64'sd212793147)),
    32'(qcoef(-64'sd213144060)),  32'(qcoef(64'sd141837029)),  32'(qcoef(64'sd9996722056))
  };

  // Hand-eye translation less tool offset, Q.30 um
  localparam logic signed [57:0] HE_OFF [3] = '{
    58'(qoff(-64'sd2884365)), 58'(qoff(64'sd55824061)), 58'(qoff(-64'sd588544457))
  };

  // Quarter-wave sine entry by truncated Taylor series, clamped to [0, 1]
  function automatic logic [30:0] sine_taylor(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0)       sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return 31'(sum);
  endfunction

  // Clamp to the 24-bit output range
  function automatic coord_t sat24(logic signed [33:0] v);
    if (v > 34'sd8388607)       return 24'sd8388607;
    else if (v < -34'sd8388608) return -24'sd8388608;
    else                        return v[23:0];
  endfunction

endpackage
`default_nettype wire

/* design/camera_point_to_base_transform.sv */
// Top level: camera point to robot base frame with workspace check.
//
//   port group   direction  handshake              content
//   in_*         input      in_valid / in_stall    camera point, flange pose
//   out_*        output     out_valid / out_stall  target, approach z, in_bounds
//   cfg_*        input      cfg_valid / cfg_ready  register index and data
//
// One point per cycle sustained while the output is not stalled. The pipe is made up of
// the table lookup (8 stages), three rotations (2 each) and the box check (2);
// the hand-eye stages run alongside the table lookup.
// All stages advance together; a held result stalls the whole pipe, nothing is lost.
// Reset clears the valid bits and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module camera_point_to_base_transform import cpbt_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire coord_t      cam_x,
  input  wire coord_t      cam_y,
  input  wire coord_t      cam_z,
  input  wire coord_t      flange_x,
  input  wire coord_t      flange_y,
  input  wire coord_t      flange_z,
  input  wire angle_t      angle_a,
  input  wire angle_t      angle_b,
  input  wire angle_t      angle_c,
  output logic             out_valid,
  input  wire logic        out_stall,
  output coord_t           target_x,
  output coord_t           target_y,
  output coord_t           target_z,
  output coord_t           approach_z,
  output logic             in_bounds,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int Latency = 16;

  logic    adv;
  logic    [Latency-1:0] vld;
  limits_t lim;

  // Pipe moves unless a finished result is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[Latency-1];
  assign cfg_ready = 1'b1;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Latency-2:0], in_valid};
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.x_lo     <= -24'sd1000000;
      lim.x_hi     <= 24'sd1000000;
      lim.y_lo     <= -24'sd1000000;
      lim.y_hi     <= 24'sd1000000;
      lim.z_lo     <= 24'sd0;
      lim.z_hi     <= 24'sd1500000;
      lim.approach <= 20'd100000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_LO:     lim.x_lo     <= cfg_data;
        CFG_X_HI:     lim.x_hi     <= cfg_data;
        CFG_Y_LO:     lim.y_lo     <= cfg_data;
        CFG_Y_HI:     lim.y_hi     <= cfg_data;
        CFG_Z_LO:     lim.z_lo     <= cfg_data;
        CFG_Z_HI:     lim.z_hi     <= cfg_data;
        CFG_APPROACH: lim.approach <= cfg_data[19:0];
        default:      ;
      endcase
    end
  end

  // Hand-eye transform of the camera point
  vec3_t he_pt;
  cpbt_hand_eye u_hand_eye (
    .clk   (clk),
    .en    (adv),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .pt    (he_pt)
  );

  // Trig of the three angles
  trig_t trig_a, trig_b, trig_c;
  cpbt_angle_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_a (
    .clk (clk), .en (adv), .ang (angle_a), .trig (trig_a)
  );
  cpbt_angle_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_b (
    .clk (clk), .en (adv), .ang (angle_b), .trig (trig_b)
  );
  cpbt_angle_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_c (
    .clk (clk), .en (adv), .ang (angle_c), .trig (trig_c)
  );

  // Alignment delay lines
  vec3_t              he_dly  [6];
  logic signed [31:0] e0_dly  [2];
  trig_t              tb_dly  [2];
  trig_t              tc_dly  [4];
  logic signed [31:0] y1_dly  [2];
  logic signed [31:0] z2_dly  [2];
  flange_t            fl_dly  [14];

  logic signed [31:0] rx_y, rx_z, ry_z, ry_x, rz_x, rz_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      he_dly[0] <= he_pt;
      for (int k = 1; k < 6; k++) he_dly[k] <= he_dly[k-1];
      e0_dly[0] <= he_dly[5].x;
      e0_dly[1] <= e0_dly[0];
      tb_dly[0] <= trig_b;
      tb_dly[1] <= tb_dly[0];
      tc_dly[0] <= trig_c;
      for (int k = 1; k < 4; k++) tc_dly[k] <= tc_dly[k-1];
      y1_dly[0] <= rx_y;
      y1_dly[1] <= y1_dly[0];
      z2_dly[0] <= ry_z;
      z2_dly[1] <= z2_dly[0];
      fl_dly[0] <= '{x: flange_x, y: flange_y, z: flange_z};
      for (int k = 1; k < 14; k++) fl_dly[k] <= fl_dly[k-1];
    end
  end

  // Rx(a) on (y, z)
  cpbt_rotate u_rot_x (
    .clk (clk), .en (adv), .u (he_dly[5].y), .w (he_dly[5].z), .trig (trig_a),
    .nu (rx_y), .nw (rx_z)
  );

  // Ry(b) on (z, x)
  cpbt_rotate u_rot_y (
    .clk (clk), .en (adv), .u (rx_z), .w (e0_dly[1]), .trig (tb_dly[1]),
    .nu (ry_z), .nw (ry_x)
  );

  // Rz(c) on (x, y)
  cpbt_rotate u_rot_z (
    .clk (clk), .en (adv), .u (ry_x), .w (y1_dly[1]), .trig (tc_dly[3]),
    .nu (rz_x), .nw (rz_y)
  );

  // Translation, box test and output register
  vec3_t fin_pt;
  assign fin_pt = '{x: rz_x, y: rz_y, z: z2_dly[1]};

  cpbt_box_check u_box_check (
    .clk        (clk),
    .en         (adv),
    .fl         (fl_dly[13]),
    .pt         (fin_pt),
    .lim        (lim),
    .target_x   (target_x),
    .target_y   (target_y),
    .target_z   (target_z),
    .approach_z (approach_z),
    .in_bounds  (in_bounds)
  );

endmodule
`default_nettype wire

/* design/cpbt_hand_eye.sv */
// Hand-eye matrix and translation: camera point to flange frame, two stages.
`timescale 1ns / 1ps
`default_nettype none
module cpbt_hand_eye import cpbt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire coord_t cam_x,
  input  wire coord_t cam_y,
  input  wire coord_t cam_z,
  output vec3_t       pt
);

  localparam logic signed [57:0] RoundHalf = 58'sd536870912;

  logic signed [55:0] prod [9];
  logic signed [57:0] sum  [3];

  // Stage 1: nine coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod[3*i]     <= HE_COEF[3*i]     * cam_x;
        prod[3*i + 1] <= HE_COEF[3*i + 1] * cam_y;
        prod[3*i + 2] <= HE_COEF[3*i + 2] * cam_z;
      end
    end
  end

  // Row sums plus translation, rounded half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = prod[3*i] + prod[3*i + 1] + prod[3*i + 2] + HE_OFF[i] + RoundHalf;
    end
  end

  // Stage 2: drop the 30 fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      pt.x <= 32'($signed(sum[0][57:30]));
      pt.y <= 32'($signed(sum[1][57:30]));
      pt.z <= 32'($signed(sum[2][57:30]));
    end
  end

endmodule
`default_nettype wire

/* design/cpbt_angle_trig.sv */
// Sine and cosine of a millidegree angle from a quarter-wave table, eight stages.
`timescale 1ns / 1ps
`default_nettype none
module cpbt_angle_trig import cpbt_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire angle_t ang,
  output trig_t       trig
);

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int NW   = $clog2(90000 * SINE_TABLE_DEPTH + 45000 + 1);
  localparam int RecipShift = 47;
  localparam longint unsigned RecipL = (64'd1 << RecipShift) / 90000;
  localparam logic [30:0] Recip = 31'(RecipL);
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(SINE_TABLE_DEPTH);

  // Constant quarter-wave table
  logic [30:0] sine_rom [SINE_TABLE_DEPTH + 1];
  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam longint unsigned Xq =
      (longint'(i) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
    assign sine_rom[i] = sine_taylor(Xq);
  end

  // Lane 0 is the sine, lane 1 the cosine (angle plus 90 deg)
  logic [18:0]        red    [2];
  logic [1:0]         quad2  [2];
  logic [16:0]        rem2   [2];
  logic [1:0]         quad3  [2];
  logic [NW-1:0]      num3   [2];
  logic [1:0]         quad4  [2];
  logic [NW-1:0]      num4   [2];
  logic [IdxW-1:0]    qest4  [2];
  logic [1:0]         quad5  [2];
  logic [IdxW-1:0]    qest5  [2];
  logic               bump5  [2];
  logic               neg6   [2];
  logic [IdxW-1:0]    idx6   [2];
  logic               neg7   [2];
  logic [30:0]        mag7   [2];

  logic signed [19:0]     sa, ca;
  logic [18:0]            red_next [2];
  logic [1:0]             quad_next [2];
  logic [16:0]            rem_next [2];
  logic [NW+30:0]         prod [2];
  logic [NW-1:0]          qmul [2];
  logic [IdxW-1:0]        idx_sum [2];

  // Stage 1: wrap into [0, 360000)
  always_comb begin
    sa = 20'(ang);
    ca = sa + 20'sd90000;
    red_next[0] = sa[19] ? 19'(sa + 20'sd360000) : 19'(sa);
    red_next[1] = ca[19] ? 19'(ca + 20'sd360000) : 19'(ca);
  end

  // Quadrant and remainder within it
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (red[l] >= 19'd270000) begin
        quad_next[l] = 2'd3;
        rem_next[l]  = 17'(red[l] - 19'd270000);
      end else if (red[l] >= 19'd180000) begin
        quad_next[l] = 2'd2;
        rem_next[l]  = 17'(red[l] - 19'd180000);
      end else if (red[l] >= 19'd90000) begin
        quad_next[l] = 2'd1;
        rem_next[l]  = 17'(red[l] - 19'd90000);
      end else begin
        quad_next[l] = 2'd0;
        rem_next[l]  = 17'(red[l]);
      end
    end
  end

  // Reciprocal quotient, its check product and the rounded index
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l]    = num3[l] * Recip;
      qmul[l]    = NW'(qest4[l]) * NW'(90000);
      idx_sum[l] = qest5[l] + IdxW'(bump5[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        // Stage 1
        red[l]   <= red_next[l];
        // Stage 2
        quad2[l] <= quad_next[l];
        rem2[l]  <= rem_next[l];
        // Stage 3: scaled remainder with half step for rounding
        quad3[l] <= quad2[l];
        num3[l]  <= NW'(rem2[l]) * NW'(SINE_TABLE_DEPTH) + NW'(45000);
        // Stage 4: quotient estimate, may be one low
        quad4[l] <= quad3[l];
        num4[l]  <= num3[l];
        qest4[l] <= prod[l][RecipShift +: IdxW];
        // Stage 5: correction flag
        quad5[l] <= quad4[l];
        qest5[l] <= qest4[l];
        bump5[l] <= (num4[l] - qmul[l]) >= NW'(90000);
        // Stage 6: mirror odd quadrants
        neg6[l]  <= quad5[l][1];
        idx6[l]  <= quad5[l][0] ? (DepthIdx - idx_sum[l]) : idx_sum[l];
        // Stage 7: table read
        neg7[l]  <= neg6[l];
        mag7[l]  <= sine_rom[idx6[l]];
      end
      // Stage 8: sign of the lower half turn
      trig.s <= neg7[0] ? -$signed({1'b0, mag7[0]}) : $signed({1'b0, mag7[0]});
      trig.c <= neg7[1] ? -$signed({1'b0, mag7[1]}) : $signed({1'b0, mag7[1]});
    end
  end

endmodule
`default_nettype wire

/* design/cpbt_rotate.sv */
// Plane rotation of one coordinate pair by a cosine/sine pair, two stages.
`timescale 1ns / 1ps
`default_nettype none
module cpbt_rotate import cpbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] u,
  input  wire logic signed [31:0] w,
  input  wire trig_t              trig,
  output logic signed [31:0]      nu,
  output logic signed [31:0]      nw
);

  localparam logic signed [65:0] RoundHalf = 66'sd536870912;

  logic signed [63:0] cu, sw, su, cw;
  logic signed [65:0] sum_u, sum_w;

  // Stage 1: four products
  always_ff @(posedge clk) begin
    if (en) begin
      cu <= trig.c * u;
      sw <= trig.s * w;
      su <= trig.s * u;
      cw <= trig.c * w;
    end
  end

  // Combine and round half up
  always_comb begin
    sum_u = cu - sw + RoundHalf;
    sum_w = su + cw + RoundHalf;
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      nu <= $signed(sum_u[61:30]);
      nw <= $signed(sum_w[61:30]);
    end
  end

endmodule
`default_nettype wire

/* design/cpbt_box_check.sv */
// Flange translation, workspace box test and output saturation, two stages.
`timescale 1ns / 1ps
`default_nettype none
module cpbt_box_check import cpbt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire flange_t fl,
  input  wire vec3_t   pt,
  input  wire limits_t lim,
  output coord_t       target_x,
  output coord_t       target_y,
  output coord_t       target_z,
  output coord_t       approach_z,
  output logic         in_bounds
);

  logic signed [32:0] tx, ty, tz;
  logic signed [33:0] tza;
  logic signed [32:0] tz_sum;

  assign tz_sum = fl.z + pt.z;

  // Stage 1: add flange position and approach height
  always_ff @(posedge clk) begin
    if (en) begin
      tx  <= fl.x + pt.x;
      ty  <= fl.y + pt.y;
      tz  <= tz_sum;
      tza <= tz_sum + $signed({1'b0, lim.approach});
    end
  end

  // Stage 2: inclusive box test on raw values, then clamp
  always_ff @(posedge clk) begin
    if (en) begin
      target_x   <= sat24(34'(tx));
      target_y   <= sat24(34'(ty));
      target_z   <= sat24(34'(tz));
      approach_z <= sat24(tza);
      in_bounds  <= (tx >= lim.x_lo) && (tx <= lim.x_hi) &&
                    (ty >= lim.y_lo) && (ty <= lim.y_hi) &&
                    (tz >= lim.z_lo) && (tz <= lim.z_hi);
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the camera point to base frame transform.
`timescale 1ns / 1ps
module testbench;
  import cpbt_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct {
    coord_t cx, cy, cz;
    coord_t fx, fy, fz;
    angle_t a, b, c;
  } point_t;

  typedef struct {
    coord_t tx, ty, tz, az;
    logic   ok;
  } target_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     cam_x = '0, cam_y = '0, cam_z = '0;
  coord_t     flange_x = '0, flange_y = '0, flange_z = '0;
  angle_t     angle_a = '0, angle_b = '0, angle_c = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  coord_t     target_x, target_y, target_z, approach_z;
  logic       in_bounds;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  point_t  pending_points[$];
  target_t expected_targets[$];

  // Predictor state: workspace box and approach height
  longint box_x_lo = -1000000, box_x_hi = 1000000;
  longint box_y_lo = -1000000, box_y_hi = 1000000;
  longint box_z_lo = 0, box_z_hi = 1500000;
  longint approach_um = 100000;

  longint hand_eye_q30[9];
  longint frame_shift_q30[3];
  longint sine_q30[TABLE_DEPTH + 1];

  int send_idle_pct = 14;
  int recv_stall_pct = 70;
  int error_count = 0;
  int points_sent = 0;
  int targets_seen = 0;
  int inside_count = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  camera_point_to_base_transform #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cam_x(cam_x), .cam_y(cam_y), .cam_z(cam_z),
    .flange_x(flange_x), .flange_y(flange_y), .flange_z(flange_z),
    .angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .approach_z(approach_z), .in_bounds(in_bounds),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Decimal in units of 1e-10 to Q1.30, nearest
  function automatic longint to_q30_coef(longint d);
    return (d * 1048576 + ((d < 0) ? -64'sd4882812 : 64'sd4882812)) / 9765625;
  endfunction

  // Offset in units of 1e-4 um to Q.30 um, nearest
  function automatic longint to_q30_um(longint k);
    return (k * 67108864 + ((k < 0) ? -64'sd312 : 64'sd312)) / 625;
  endfunction

  // Constant tables: hand-eye matrix, translation and quarter-wave sine
  function automatic void build_constants();
    longint unsigned x, x2, term;
    longint sum;
    hand_eye_q30 = '{to_q30_coef(-64'sd23177327), to_q30_coef(64'sd9998959726),
                     to_q30_coef(-64'sd142362951), to_q30_coef(-64'sd9997701357),
                     to_q30_coef(-64'sd26204112), to_q30_coef(-64'sd212793147),
                     to_q30_coef(-64'sd213144060), to_q30_coef(64'sd141837029),
                     to_q30_coef(64'sd9996722056)};
    frame_shift_q30 = '{to_q30_um(-64'sd2884365), to_q30_um(64'sd55824061),
                        to_q30_um(-64'sd588544457)};
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      x = (longint'(i) * 1686629713 + TABLE_DEPTH / 2) / TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      sine_q30[i] = sum;
    end
  endfunction

  // Nearest um, ties toward +inf
  function automatic longint round_um(longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sine_of(longint mdeg);
    longint w, quad, rem, idx, v;
    w = ((mdeg % 360000) + 360000) % 360000;
    quad = w / 90000;
    rem = w % 90000;
    idx = (rem * TABLE_DEPTH + 45000) / 90000;
    if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
    v = (quad % 2 == 1) ? sine_q30[TABLE_DEPTH - idx] : sine_q30[idx];
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic void turn(inout longint u, inout longint w, input longint mdeg);
    longint cs, sn, nu, nw;
    cs = sine_of(mdeg + 90000);
    sn = sine_of(mdeg);
    nu = round_um(cs * u - sn * w);
    nw = round_um(sn * u + cs * w);
    u = nu;
    w = nw;
  endfunction

  function automatic coord_t clamp24(longint v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return coord_t'(v);
  endfunction

  // Base-frame target of one camera point under the current flange pose
  function automatic target_t base_target(point_t p);
    longint cam[3], e[3];
    longint tx, ty, tz;
    target_t r;
    cam = '{longint'(p.cx), longint'(p.cy), longint'(p.cz)};
    for (int i = 0; i < 3; i++)
      e[i] = round_um(hand_eye_q30[3*i] * cam[0] + hand_eye_q30[3*i+1] * cam[1]
                      + hand_eye_q30[3*i+2] * cam[2] + frame_shift_q30[i]);
    turn(e[1], e[2], longint'(p.a));
    turn(e[2], e[0], longint'(p.b));
    turn(e[0], e[1], longint'(p.c));
    tx = longint'(p.fx) + e[0];
    ty = longint'(p.fy) + e[1];
    tz = longint'(p.fz) + e[2];
    r.ok = tx >= box_x_lo && tx <= box_x_hi && ty >= box_y_lo && ty <= box_y_hi &&
           tz >= box_z_lo && tz <= box_z_hi;
    r.tx = clamp24(tx);
    r.ty = clamp24(ty);
    r.tz = clamp24(tz);
    r.az = clamp24(tz + approach_um);
    return r;
  endfunction

  // Driver: next point goes out once the current one has transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_targets.push_back(base_target('{cam_x, cam_y, cam_z, flange_x,
          flange_y, flange_z, angle_a, angle_b, angle_c}));
        points_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          cam_x <= p.cx; cam_y <= p.cy; cam_z <= p.cz;
          flange_x <= p.fx; flange_y <= p.fy; flange_z <= p.fz;
          angle_a <= p.a; angle_b <= p.b; angle_c <= p.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report(string field, longint want, longint got);
    if (want != got) begin
      error_count++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_targets.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none, got x=%0d y=%0d z=%0d",
                 $time, target_x, target_y, target_z);
      end else begin
        target_t w;
        w = expected_targets.pop_front();
        report("target_x", w.tx, target_x);
        report("target_y", w.ty, target_y);
        report("target_z", w.tz, target_z);
        report("approach_z", w.az, approach_z);
        report("in_bounds", w.ok, in_bounds);
        if (w.ok) inside_count++;
      end
      targets_seen++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      3'(CFG_X_LO):     box_x_lo = longint'(coord_t'(value));
      3'(CFG_X_HI):     box_x_hi = longint'(coord_t'(value));
      3'(CFG_Y_LO):     box_y_lo = longint'(coord_t'(value));
      3'(CFG_Y_HI):     box_y_hi = longint'(coord_t'(value));
      3'(CFG_Z_LO):     box_z_lo = longint'(coord_t'(value));
      3'(CFG_Z_HI):     box_z_hi = longint'(coord_t'(value));
      3'(CFG_APPROACH): approach_um = longint'(value[19:0]);
      default: ;
    endcase
  endtask

  task automatic write_box(logic [23:0] xl, logic [23:0] xh, logic [23:0] yl,
                           logic [23:0] yh, logic [23:0] zl, logic [23:0] zh,
                           logic [23:0] appr);
    write_reg(3'(CFG_X_LO), xl);
    write_reg(3'(CFG_X_HI), xh);
    write_reg(3'(CFG_Y_LO), yl);
    write_reg(3'(CFG_Y_HI), yh);
    write_reg(3'(CFG_Z_LO), zl);
    write_reg(3'(CFG_Z_HI), zh);
    write_reg(3'(CFG_APPROACH), appr);
    write_reg(CFG_UNUSED, 24'($urandom));
  endtask

  task automatic queue_point(int cx, int cy, int cz, int fx, int fy, int fz,
                             int a, int b, int c);
    pending_points.push_back('{coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(fx),
      coord_t'(fy), coord_t'(fz), angle_t'(a), angle_t'(b), angle_t'(c)});
  endtask

  function automatic int pick_angle();
    case ($urandom_range(9))
      0: return $urandom_range(262143);
      1: return 90000 * $urandom_range(4) - 180000;
      default: return $urandom_range(360000) - 180000;
    endcase
  endfunction

  // Mostly points near a workcell, some raw full-range noise
  task automatic queue_random(int n);
    repeat (n) begin
      if ($urandom_range(4) == 0)
        queue_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
      else
        queue_point($urandom_range(1200000) - 600000, $urandom_range(1200000) - 600000,
                    $urandom_range(1200000) - 200000, $urandom_range(1400000) - 700000,
                    $urandom_range(1400000) - 700000, $urandom_range(1400000) + 100000,
                    pick_angle(), pick_angle(), pick_angle());
    end
  endtask

  task automatic wait_idle();
    wait (pending_points.size() == 0 && !in_valid && expected_targets.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  initial begin
    build_constants();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed points under the reset box
    queue_point(0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_point(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0);
    queue_point(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0);
    queue_point(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 180000, -180000, 90000);
    queue_point(100000, -50000, 300000, 0, 0, 800000, 0, 0, 0);
    queue_point(100000, -50000, 300000, 0, 0, 800000, 90000, 0, 0);
    queue_point(100000, -50000, 300000, 0, 0, 800000, 0, 90000, 0);
    queue_point(100000, -50000, 300000, 0, 0, 800000, 0, 0, 90000);
    queue_point(100000, -50000, 300000, 0, 0, 800000, -90000, -90000, -90000);
    queue_point(100000, -50000, 300000, 0, 0, 800000, 180000, 180000, 180000);
    queue_point(100000, -50000, 300000, 0, 0, 800000, -180000, -180000, -180000);
    // angle codes beyond +-180 deg wrap round
    queue_point(20000, 30000, 40000, 0, 0, 500000, 262143, -262144, 200000);
    queue_point(20000, 30000, 40000, 0, 0, 500000, 45000, 44, 43);
    queue_point(20000, 30000, 40000, 0, 0, 500000, 89999, 89956, 1);
    // target just inside the box and well outside it
    queue_point(0, 0, 0, 1000000, 0, 700000, 0, 0, 0);
    queue_point(0, 0, 0, 4000000, 0, 700000, 0, 0, 0);
    queue_point(0, 0, 0, 0, -3000000, -500000, 0, 0, 0);
    // saturation on the far corners
    queue_point(CMAX, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0);
    queue_point(0, CMIN, 0, CMIN, CMIN, CMIN, 0, 0, 0);
    queue_point(0, 0, 0, 0, 0, CMAX - 50000, 0, 0, 0);
    queue_random(260);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin send_idle_pct = 70; recv_stall_pct = 14; end
      if (phase == 4) begin send_idle_pct = 0; recv_stall_pct = 0; end
      case (phase)
        // widest box, largest approach height
        0: write_box(24'(CMIN), 24'(CMAX), 24'(CMIN), 24'(CMAX), 24'(CMIN), 24'(CMAX),
                     24'hF_FFFFF);
        // crossed limits give an empty box, no approach height
        1: write_box(24'(CMAX), 24'(CMIN), 24'(CMAX), 24'(CMIN), 24'(CMAX), 24'(CMIN),
                     24'h0);
        // tight cell, upper data bits set beyond the 20-bit approach field
        2: write_box(24'(-300000), 24'(300000), 24'(-300000), 24'(300000),
                     24'(200000), 24'(1200000), 24'hF0_0000 | 24'd50000);
        3: write_box(24'($urandom_range(1000000)) - 24'd1000000, 24'($urandom_range(1000000)),
                     24'($urandom_range(1000000)) - 24'd1000000, 24'($urandom_range(1000000)),
                     24'($urandom_range(500000)), 24'($urandom_range(2000000)) + 24'd500000,
                     24'($urandom));
        4: write_box(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom));
        default: write_box(24'(-1000000), 24'(1000000), 24'(-1000000), 24'(1000000),
                           24'(0), 24'(1500000), 24'(100000));
      endcase
      queue_random(215);
      wait_idle();
    end

    $display("covered %0d points, %0d results (%0d inside the box), %0d register writes",
             points_sent, targets_seen, inside_count, cfg_writes);
    $display("six box settings including full-range and crossed limits");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
